// ===== hdl/lcsr_pkg.sv =====
`default_nettype none
package lcsr_pkg;

  // Request codes carried on the input tuser.
  localparam logic [1:0] REQ_PAT_CHAR  = 2'd0;
  localparam logic [1:0] REQ_NAME_CHAR = 2'd1;
  localparam logic [1:0] REQ_CLEAR_PAT = 2'd2;
  localparam logic [1:0] REQ_END_NAME  = 2'd3;

  // Step codes kept in the direction grid.
  localparam logic [1:0] DIR_DIAG = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_UP   = 2'd3;

  // At most this many ranges go out per name.
  localparam int unsigned RANGE_CAP = 32;

  // Output item kinds.
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  typedef logic [6:0] score_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL_RD,
    ST_CELL_EV,
    ST_TB_RD,
    ST_TB_EV,
    ST_EM_RD,
    ST_EM_LD,
    ST_SCORE
  } state_e;

  // Fold ASCII upper-case letters to lower case.
  function automatic logic [15:0] fold(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = c + 16'h0020;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lcsr_ram.sv =====
`default_nettype none
module lcsr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                           wdata_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/lcs_score_with_match_runs_core.sv =====
`default_nettype none
// Channel   | Dir | tdata (low bit up)                                   | tuser      | tlast
// s_axis    | in  | char_code[15:0]                                      | req_type   | -
// m_axis    | out | range_start, range_length, similarity, longest_run,  | item_kind  | last
//           |     | truncated, zero fill to 32 bits                      |            |
// Character loads and clears are taken in the idle state. An end-of-name request fills the
// table cell by cell, row by row (name length times pattern length cells), then traces
// back (at most name plus pattern length steps), then sends each range while the output
// is ready, and the score item after it. The memories have registered reads, so each
// read has a state of its own before the state that uses the data.
// Reset clears the lengths, flags and control; stores hold garbage until written.
// A stalled output holds the sequencer before each range and before the score item;
// requests are taken again as soon as the score item is loaded into the output register.
module lcs_score_with_match_runs_core #(
  parameter int unsigned MAX_NAME_LEN    = 64,
  parameter int unsigned MAX_PATTERN_LEN = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,  // char_code
  input  wire  [1:0]  s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // range_start, range_length, similarity,
                                       // longest_run, truncated, zero fill
  output logic        m_axis_tuser_o,  // item_kind
  output logic        m_axis_tlast_o   // last
);

  localparam int unsigned NAW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int unsigned NLW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned PAW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned PLW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned SDEPTH = 2 * (MAX_PATTERN_LEN + 1);
  localparam int unsigned SAW = $clog2(SDEPTH);
  localparam int unsigned DDEPTH = MAX_NAME_LEN * MAX_PATTERN_LEN;
  localparam int unsigned DAW = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int unsigned RUNW = 13;

  lcsr_pkg::state_e state_q, state_d;

  logic [NLW-1:0] name_len_q;
  logic [PLW-1:0] pat_len_q;
  logic           name_ovf_q, pat_ovf_q;
  logic [NLW-1:0] y_q;
  logic [PLW-1:0] x_q;
  logic           row_q;
  logic [DAW-1:0] dbase_q;
  logic [15:0]    nc_q;
  lcsr_pkg::score_t left_q, diag_q, sim_q, longest_q, run_len_q;
  logic [5:0]     run_start_q;
  logic [NLW-1:0] run_cnt_q;
  logic [NAW-1:0] em_idx_q;
  logic [5:0]     em_num_q;

  logic        out_valid_q, out_kind_q, out_trunc_q, out_last_q;
  logic [5:0]  out_start_q;
  lcsr_pkg::score_t out_len_q, out_sim_q, out_long_q;

  // Memory ports.
  logic           pat_we, name_we, sc_we, dir_we, run_we;
  logic [PAW-1:0] pat_waddr, pat_raddr;
  logic [NAW-1:0] name_waddr, name_raddr, run_waddr, run_raddr;
  logic [SAW-1:0] sc_waddr, sc_raddr;
  logic [DAW-1:0] dir_waddr, dir_raddr;
  logic [15:0]    pat_rdata, name_rdata;
  lcsr_pkg::score_t sc_rdata, sc_wdata;
  logic [1:0]     dir_rdata, dir_wdata;
  logic [RUNW-1:0] run_rdata, run_wdata;

  logic in_acc, out_acc;
  logic x_zero, y_zero, tb_done, flush_push, last_em;
  lcsr_pkg::score_t up_val, cell_val;
  logic [1:0] cell_dir;
  logic [15:0] pc_fold;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == lcsr_pkg::ST_IDLE);

  assign x_zero     = (x_q == '0);
  assign y_zero     = (y_q == '0);
  assign tb_done    = x_zero || y_zero;
  assign flush_push = tb_done && (run_len_q != '0);
  assign last_em    = (em_idx_q == '0) ||
                      (em_num_q == 6'(lcsr_pkg::RANGE_CAP - 1));

  // Cell evaluation: diagonal on match, left if strictly greater, else up.
  assign up_val  = (y_q == NLW'(1)) ? '0 : sc_rdata;
  assign pc_fold = lcsr_pkg::fold(pat_rdata);
  always_comb begin
    if (nc_q == pc_fold) begin
      cell_val = diag_q + 7'd1;
      cell_dir = lcsr_pkg::DIR_DIAG;
    end else if (left_q > up_val) begin
      cell_val = left_q;
      cell_dir = lcsr_pkg::DIR_LEFT;
    end else begin
      cell_val = up_val;
      cell_dir = lcsr_pkg::DIR_UP;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcsr_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tuser_i == lcsr_pkg::REQ_END_NAME) begin
          if (name_len_q == '0 || pat_len_q == '0) begin
            state_d = lcsr_pkg::ST_SCORE;
          end else begin
            state_d = lcsr_pkg::ST_ROW_RD;
          end
        end
      end
      lcsr_pkg::ST_ROW_RD:  state_d = lcsr_pkg::ST_ROW_LD;
      lcsr_pkg::ST_ROW_LD:  state_d = lcsr_pkg::ST_CELL_RD;
      lcsr_pkg::ST_CELL_RD: state_d = lcsr_pkg::ST_CELL_EV;
      lcsr_pkg::ST_CELL_EV: begin
        if (x_q != pat_len_q) begin
          state_d = lcsr_pkg::ST_CELL_RD;
        end else if (y_q != name_len_q) begin
          state_d = lcsr_pkg::ST_ROW_RD;
        end else begin
          state_d = lcsr_pkg::ST_TB_RD;
        end
      end
      lcsr_pkg::ST_TB_RD: begin
        if (!tb_done) begin
          state_d = lcsr_pkg::ST_TB_EV;
        end else if (run_cnt_q != '0 || flush_push) begin
          state_d = lcsr_pkg::ST_EM_RD;
        end else begin
          state_d = lcsr_pkg::ST_SCORE;
        end
      end
      lcsr_pkg::ST_TB_EV: state_d = lcsr_pkg::ST_TB_RD;
      lcsr_pkg::ST_EM_RD: begin
        if (!out_valid_q) begin
          state_d = lcsr_pkg::ST_EM_LD;
        end
      end
      lcsr_pkg::ST_EM_LD: state_d = last_em ? lcsr_pkg::ST_SCORE : lcsr_pkg::ST_EM_RD;
      lcsr_pkg::ST_SCORE: begin
        if (!out_valid_q) begin
          state_d = lcsr_pkg::ST_IDLE;
        end
      end
      default: state_d = lcsr_pkg::ST_IDLE;
    endcase
  end

  // Memory controls for each state.
  always_comb begin
    pat_we     = in_acc && s_axis_tuser_i == lcsr_pkg::REQ_PAT_CHAR &&
                 pat_len_q < PLW'(MAX_PATTERN_LEN);
    pat_waddr  = PAW'(pat_len_q);
    name_we    = in_acc && s_axis_tuser_i == lcsr_pkg::REQ_NAME_CHAR &&
                 name_len_q < NLW'(MAX_NAME_LEN);
    name_waddr = NAW'(name_len_q);
    name_raddr = NAW'(y_q - NLW'(1));
    pat_raddr  = PAW'(x_q - PLW'(1));
    sc_raddr   = SAW'(x_q) + (row_q ? SAW'(0) : SAW'(MAX_PATTERN_LEN + 1));
    sc_waddr   = SAW'(x_q) + (row_q ? SAW'(MAX_PATTERN_LEN + 1) : SAW'(0));
    sc_wdata   = cell_val;
    sc_we      = (state_q == lcsr_pkg::ST_CELL_EV);
    dir_waddr  = dbase_q + DAW'(x_q) - DAW'(1);
    dir_raddr  = dbase_q + DAW'(x_q) - DAW'(1);
    dir_wdata  = cell_dir;
    dir_we     = (state_q == lcsr_pkg::ST_CELL_EV);
    run_waddr  = NAW'(run_cnt_q);
    run_wdata  = {run_len_q, run_start_q};
    run_we     = ((state_q == lcsr_pkg::ST_TB_EV) && dir_rdata != lcsr_pkg::DIR_DIAG &&
                  run_len_q != '0) ||
                 ((state_q == lcsr_pkg::ST_TB_RD) && flush_push);
    run_raddr  = em_idx_q;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcsr_pkg::ST_IDLE;
      name_len_q  <= '0;
      pat_len_q   <= '0;
      name_ovf_q  <= 1'b0;
      pat_ovf_q   <= 1'b0;
      run_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        lcsr_pkg::ST_IDLE: begin
          if (in_acc) begin
            unique case (s_axis_tuser_i)
              lcsr_pkg::REQ_PAT_CHAR: begin
                if (pat_we) pat_len_q <= pat_len_q + PLW'(1);
                else        pat_ovf_q <= 1'b1;
              end
              lcsr_pkg::REQ_NAME_CHAR: begin
                if (name_we) name_len_q <= name_len_q + NLW'(1);
                else         name_ovf_q <= 1'b1;
              end
              lcsr_pkg::REQ_CLEAR_PAT: begin
                pat_len_q <= '0;
                pat_ovf_q <= 1'b0;
              end
              lcsr_pkg::REQ_END_NAME: begin
                y_q       <= NLW'(1);
                row_q     <= 1'b1;
                dbase_q   <= '0;
                sim_q     <= '0;
                longest_q <= '0;
                run_len_q <= '0;
                run_cnt_q <= '0;
                em_num_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        lcsr_pkg::ST_ROW_RD: ;
        lcsr_pkg::ST_ROW_LD: begin
          nc_q   <= lcsr_pkg::fold(name_rdata);
          x_q    <= PLW'(1);
          left_q <= '0;
          diag_q <= '0;
        end
        lcsr_pkg::ST_CELL_RD: ;
        lcsr_pkg::ST_CELL_EV: begin
          left_q <= cell_val;
          diag_q <= up_val;
          if (x_q != pat_len_q) begin
            x_q <= x_q + PLW'(1);
          end else if (y_q != name_len_q) begin
            y_q     <= y_q + NLW'(1);
            row_q   <= !row_q;
            dbase_q <= dbase_q + DAW'(MAX_PATTERN_LEN);
          end else begin
            sim_q <= cell_val;
          end
        end
        lcsr_pkg::ST_TB_RD: begin
          if (flush_push) begin
            run_cnt_q <= run_cnt_q + NLW'(1);
            em_idx_q  <= NAW'(run_cnt_q);
            if (run_len_q > longest_q) longest_q <= run_len_q;
          end else begin
            em_idx_q <= NAW'(run_cnt_q - NLW'(1));
          end
        end
        lcsr_pkg::ST_TB_EV: begin
          if (dir_rdata == lcsr_pkg::DIR_DIAG) begin
            run_len_q   <= run_len_q + 7'd1;
            run_start_q <= 6'(y_q - NLW'(1));
          end else if (run_len_q != '0) begin
            run_cnt_q <= run_cnt_q + NLW'(1);
            run_len_q <= '0;
            if (run_len_q > longest_q) longest_q <= run_len_q;
          end
          if (dir_rdata != lcsr_pkg::DIR_UP) begin
            x_q <= x_q - PLW'(1);
          end
          if (dir_rdata != lcsr_pkg::DIR_LEFT) begin
            y_q     <= y_q - NLW'(1);
            dbase_q <= dbase_q - DAW'(MAX_PATTERN_LEN);
          end
        end
        lcsr_pkg::ST_EM_RD: ;
        lcsr_pkg::ST_EM_LD: begin
          out_valid_q <= 1'b1;
          out_kind_q  <= lcsr_pkg::KIND_RANGE;
          out_start_q <= run_rdata[5:0];
          out_len_q   <= run_rdata[12:6];
          out_sim_q   <= '0;
          out_long_q  <= '0;
          out_trunc_q <= 1'b0;
          out_last_q  <= 1'b0;
          em_num_q    <= em_num_q + 6'd1;
          em_idx_q    <= em_idx_q - NAW'(1);
        end
        lcsr_pkg::ST_SCORE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= lcsr_pkg::KIND_SCORE;
            out_start_q <= '0;
            out_len_q   <= '0;
            out_sim_q   <= sim_q;
            out_long_q  <= longest_q;
            out_trunc_q <= name_ovf_q | pat_ovf_q;
            out_last_q  <= 1'b1;
            name_len_q  <= '0;
            name_ovf_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register drives the result stream.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0000, out_trunc_q, out_long_q, out_sim_q, out_len_q,
                            out_start_q};

  lcsr_ram #(.WIDTH(16), .DEPTH(MAX_PATTERN_LEN)) u_pat_ram (
    .clk_i(clk_i), .we_i(pat_we), .waddr_i(pat_waddr), .wdata_i(s_axis_tdata_i),
    .raddr_i(pat_raddr), .rdata_o(pat_rdata)
  );

  lcsr_ram #(.WIDTH(16), .DEPTH(MAX_NAME_LEN)) u_name_ram (
    .clk_i(clk_i), .we_i(name_we), .waddr_i(name_waddr), .wdata_i(s_axis_tdata_i),
    .raddr_i(name_raddr), .rdata_o(name_rdata)
  );

  lcsr_ram #(.WIDTH(7), .DEPTH(SDEPTH)) u_score_ram (
    .clk_i(clk_i), .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(sc_wdata),
    .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  lcsr_ram #(.WIDTH(2), .DEPTH(DDEPTH)) u_dir_ram (
    .clk_i(clk_i), .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata)
  );

  lcsr_ram #(.WIDTH(RUNW), .DEPTH(MAX_NAME_LEN)) u_run_ram (
    .clk_i(clk_i), .we_i(run_we), .waddr_i(run_waddr), .wdata_i(run_wdata),
    .raddr_i(run_raddr), .rdata_o(run_rdata)
  );

  // The score item is the only last item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == m_axis_tlast_o))
    else $error("item kind and last disagree");

  // The longest run cannot exceed the subsequence length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[26:20] <= m_axis_tdata_o[19:13]))
    else $error("longest run above similarity");

  // Traceback stays inside the filled table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcsr_pkg::ST_TB_EV) |-> (x_q <= pat_len_q && y_q <= name_len_q && !tb_done))
    else $error("traceback left the table");

  // Runs found never outnumber name characters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcsr_pkg::ST_EM_RD) |-> (run_cnt_q <= name_len_q && run_cnt_q != '0))
    else $error("run count out of range");

endmodule
`default_nettype wire

// ===== dv/tb_lcs_score_with_match_runs_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_lcs_score_with_match_runs_core;

  localparam int unsigned NAME_CAP = 64;
  localparam int unsigned PAT_CAP  = 64;
  localparam int unsigned RUN_CHARS = 12;
  localparam int unsigned STALL_LIMIT = 60000;
  localparam int unsigned TAIL_CYCLES = 200;

  // One output item, as it travels on m_axis.
  typedef struct packed {
    logic       kind;
    logic [5:0] start;
    logic [6:0] len;
    logic [6:0] sim;
    logic [6:0] run;
    logic       trunc;
    logic       last;
  } lcs_item_t;

  // One row of the directed stimulus; typed rows carry their own score item.
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] ch;
    logic        typed;
    logic [6:0]  sim;
    logic        trunc;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire         m_user;
  wire         m_last;

  lcs_score_with_match_runs_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block state.
  logic [15:0] pat_chars [PAT_CAP];
  logic [15:0] name_chars [NAME_CAP];
  int unsigned pat_len = 0;
  int unsigned name_len = 0;
  logic        name_dropped = 1'b0;
  logic        pat_dropped = 1'b0;

  lcs_item_t   pending_items [$];
  int unsigned error_count = 0;
  int unsigned idle_send = 0;
  int unsigned idle_recv = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_count = 0;
  int unsigned scores_seen = 0;

  function automatic logic [15:0] to_lower_ascii(input logic [15:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Append one expected item at the tail of the queue.
  task automatic queue_item(input lcs_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Fill the LCS table, trace back, and queue the ranges and the score item.
  task automatic score_name();
    int n, m, x, y, steps, i, run_start, run_len, count, longest, sim;
    logic [15:0] nc;
    int step_grid [NAME_CAP][PAT_CAP];
    int prev_row [PAT_CAP+1];
    int cur_row [PAT_CAP+1];
    int path_step [NAME_CAP+PAT_CAP];
    int path_row [NAME_CAP+PAT_CAP];
    lcs_item_t it;
    n = name_len;
    m = pat_len;
    sim = 0;
    longest = 0;
    count = 0;
    run_start = 0;
    run_len = 0;
    if (n > 0 && m > 0) begin
      for (x = 0; x <= m; x++) prev_row[x] = 0;
      for (y = 1; y <= n; y++) begin
        nc = to_lower_ascii(name_chars[y-1]);
        cur_row[0] = 0;
        for (x = 1; x <= m; x++) begin
          if (nc == to_lower_ascii(pat_chars[x-1])) begin
            cur_row[x] = prev_row[x-1] + 1;
            step_grid[y-1][x-1] = lcsr_pkg::DIR_DIAG;
          end else if (cur_row[x-1] > prev_row[x]) begin
            cur_row[x] = cur_row[x-1];
            step_grid[y-1][x-1] = lcsr_pkg::DIR_LEFT;
          end else begin
            cur_row[x] = prev_row[x];
            step_grid[y-1][x-1] = lcsr_pkg::DIR_UP;
          end
        end
        prev_row = cur_row;
      end
      sim = prev_row[m];
      // Walk back from the last cell.
      x = m;
      y = n;
      steps = 0;
      while (x > 0 && y > 0) begin
        path_step[steps] = step_grid[y-1][x-1];
        path_row[steps] = y - 1;
        steps++;
        if (step_grid[y-1][x-1] == lcsr_pkg::DIR_DIAG) begin
          x--;
          y--;
        end else if (step_grid[y-1][x-1] == lcsr_pkg::DIR_LEFT) begin
          x--;
        end else begin
          y--;
        end
      end
      // Runs of diagonal steps in ascending order; the last pass flushes the open run.
      for (i = steps; i >= 0; i--) begin
        if (i > 0 && path_step[i-1] == lcsr_pkg::DIR_DIAG) begin
          if (run_len == 0) run_start = path_row[i-1];
          run_len++;
        end else if (run_len != 0) begin
          if (count < lcsr_pkg::RANGE_CAP) begin
            it = '0;
            it.kind = lcsr_pkg::KIND_RANGE;
            it.start = run_start[5:0];
            it.len = run_len[6:0];
            queue_item(it);
            count++;
          end
          if (run_len > longest) longest = run_len;
          run_len = 0;
        end
      end
    end
    it = '0;
    it.kind = lcsr_pkg::KIND_SCORE;
    it.sim = sim[6:0];
    it.run = longest[6:0];
    it.trunc = name_dropped | pat_dropped;
    it.last = 1'b1;
    queue_item(it);
    name_len = 0;
    name_dropped = 1'b0;
  endtask

  // Offer one request and update the shadow state once it is taken.
  task automatic send_req(input logic [1:0] req, input logic [15:0] ch);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_send) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= req;
    s_data <= ch;
    do @(posedge clk_i); while (!s_ready);
    case (req)
      lcsr_pkg::REQ_PAT_CHAR: begin
        if (pat_len < PAT_CAP) pat_chars[pat_len++] = ch;
        else pat_dropped = 1'b1;
      end
      lcsr_pkg::REQ_NAME_CHAR: begin
        if (name_len < NAME_CAP) name_chars[name_len++] = ch;
        else name_dropped = 1'b1;
      end
      lcsr_pkg::REQ_CLEAR_PAT: begin
        pat_len = 0;
        pat_dropped = 1'b0;
      end
      default: score_name();
    endcase
  endtask

  task automatic release_bus();
    @(negedge clk_i);
    s_valid <= 1'b0;
  endtask

  // Wait until every queued result has left, then let the block settle.
  task automatic drain();
    release_bus();
    while (pending_items.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      case ($urandom_range(5))
        0: return 16'h0061;
        1: return 16'h0062;
        2: return 16'h0041;
        3: return 16'h0042;
        4: return 16'h0063;
        default: return 16'h0043;
      endcase
    end else if (sel < 6) begin
      case ($urandom_range(5))
        0: return 16'h0040;
        1: return 16'h005B;
        2: return 16'h005A;
        3: return 16'h007A;
        4: return 16'h0060;
        default: return 16'h007B;
      endcase
    end
    return 16'($urandom_range(65535));
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(19) == 0) return $urandom_range(66, 62);
    return $urandom_range(8);
  endfunction

  // One well-formed name, now and then with a fresh pattern, with some noise.
  task automatic random_name();
    int unsigned k, plen, nlen;
    if ($urandom_range(9) < 3) begin
      send_req(lcsr_pkg::REQ_CLEAR_PAT, 16'($urandom));
      plen = pick_len();
      for (k = 0; k < plen; k++) send_req(lcsr_pkg::REQ_PAT_CHAR, pick_char());
    end
    nlen = pick_len();
    for (k = 0; k < nlen; k++) begin
      if ($urandom_range(19) == 0) send_req(2'($urandom_range(3)), 16'($urandom));
      else send_req(lcsr_pkg::REQ_NAME_CHAR, pick_char());
    end
    send_req(lcsr_pkg::REQ_END_NAME, 16'($urandom));
  endtask

  // Alternating letters give a separate short run at every other position.
  task automatic many_runs();
    int unsigned k;
    send_req(lcsr_pkg::REQ_CLEAR_PAT, 16'h0000);
    for (k = 0; k < RUN_CHARS; k++)
      send_req(lcsr_pkg::REQ_PAT_CHAR, (k % 2) ? 16'h0078 : 16'h0061);
    for (k = 0; k < RUN_CHARS; k++)
      send_req(lcsr_pkg::REQ_NAME_CHAR, (k % 2) ? 16'h0079 : 16'h0041);
    send_req(lcsr_pkg::REQ_END_NAME, 16'hFFFF);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_ready <= ($urandom_range(99) >= idle_recv);
    end
  end

  // Output check against the oldest expectation.
  always @(posedge clk_i) begin
    lcs_item_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_items.size() == 0) begin
        report_mismatch("unexpected item, tuser", m_user, 0);
      end else begin
        want = pending_items.pop_front();
        if (m_user !== want.kind) report_mismatch("item_kind", m_user, want.kind);
        if (m_data[5:0] !== want.start) report_mismatch("range_start", m_data[5:0], want.start);
        if (m_data[12:6] !== want.len) report_mismatch("range_length", m_data[12:6], want.len);
        if (m_data[19:13] !== want.sim) report_mismatch("similarity", m_data[19:13], want.sim);
        if (m_data[26:20] !== want.run) report_mismatch("longest_run", m_data[26:20], want.run);
        if (m_data[27] !== want.trunc) report_mismatch("truncated", m_data[27], want.trunc);
        if (m_data[31:28] !== 4'b0) report_mismatch("tdata fill", m_data[31:28], 0);
        if (m_last !== want.last) report_mismatch("last", m_last, want.last);
        if (want.kind == lcsr_pkg::KIND_SCORE) scores_seen++;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_count <= 0;
    end else if (rst_ni) begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  stim_row_t directed [] = '{
    '{lcsr_pkg::REQ_END_NAME,  16'h0000, 1'b1, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0061, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_END_NAME,  16'hFFFF, 1'b1, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_PAT_CHAR,  16'h0041, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_PAT_CHAR,  16'h0062, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_PAT_CHAR,  16'hFFFF, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_PAT_CHAR,  16'h0000, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_PAT_CHAR,  16'h005A, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0061, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0042, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0078, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'hFFFF, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0000, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h007A, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_END_NAME,  16'h1234, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0040, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h005B, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0060, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h007B, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_END_NAME,  16'h0000, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_CLEAR_PAT, 16'hFFFF, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_NAME_CHAR, 16'h0071, 1'b0, 7'd0, 1'b0},
    '{lcsr_pkg::REQ_END_NAME,  16'h0000, 1'b1, 7'd0, 1'b0}
  };

  initial begin
    int unsigned r, phase;
    lcs_item_t typed_item;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; typed rows replace the computed score item with their own.
    for (r = 0; r < directed.size(); r++) begin
      send_req(directed[r].req, directed[r].ch);
      if (directed[r].typed) begin
        typed_item = '0;
        typed_item.kind = lcsr_pkg::KIND_SCORE;
        typed_item.sim = directed[r].sim;
        typed_item.trunc = directed[r].trunc;
        typed_item.last = 1'b1;
        pending_items[pending_items.size() - 1] = typed_item;
      end
    end
    drain();

    // Random names under three idling mixes.
    for (phase = 0; phase < 3; phase++) begin
      idle_send = (phase == 0) ? 23 : (phase == 1) ? 88 : 0;
      idle_recv = (phase == 0) ? 88 : (phase == 1) ? 23 : 0;
      if (phase == 1) many_runs();
      repeat (2) random_name();
      drain();
    end

    // Long receiver hold-off while names keep coming, so the input backs up.
    hold_cycles = 600;
    for (r = 0; r < 2; r++) random_name();
    drain();

    release_bus();
    while (pending_items.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/lcsr_pkg.sv
hdl/lcsr_ram.sv
hdl/lcs_score_with_match_runs_core.sv
dv/tb_lcs_score_with_match_runs_core.sv
